// ----- sv/adam_pkg.sv -----
// Shared types, constants and register codes of the Adam update block.
package adam_pkg;

   localparam int unsigned IDX_W   = 12;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned BETA_W  = 16;
   localparam int unsigned FRAC_W  = 24;
   localparam int unsigned CSR_AW  = 4;
   localparam int unsigned CSR_DW  = 32;

   // iterative unit sizes
   localparam int unsigned MQ_W    = 32;   // moment quotient bits
   localparam int unsigned MD_W    = 32;   // moment divisor bits
   localparam int unsigned ROOT_W  = 28;
   localparam int unsigned DEN_W   = 29;
   localparam int unsigned RATIO_W = 39;

   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

   localparam logic KIND_ELEMENT = 1'b0;
   localparam logic KIND_STEP    = 1'b1;

   localparam logic [15:0] BETA_FIRST_RST  = 16'd58982;
   localparam logic [15:0] BETA_SECOND_RST = 16'd65470;
   localparam logic [23:0] EPS_TERM_RST    = 24'd1;
   localparam logic [23:0] STEP_SIZE_RST   = 24'd16777;

   typedef enum logic [1:0] {
      REG_BETA_FIRST,
      REG_BETA_SECOND,
      REG_EPS_TERM,
      REG_STEP_SIZE
   } reg_idx_type;

   typedef struct packed {
      logic               kind;
      logic [11:0]        index;
      logic signed [31:0] weight;
      logic signed [31:0] gradient;
   } req_type;

   typedef struct packed {
      logic [11:0]        index_out;
      logic signed [31:0] new_weight;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic [11:0]        addr;
      logic signed [31:0] weight;
      logic               neg;
      logic               flag;
      logic               nostep;
      logic               msat;
      logic               vsat;
   } div_side_type;

   typedef struct packed {
      logic [11:0]        addr;
      logic signed [31:0] weight;
      logic               neg;
      logic               flag;
      logic               nostep;
      logic [30:0]        mh;
   } root_side_type;

   typedef struct packed {
      logic [11:0]        addr;
      logic signed [31:0] weight;
      logic               neg;
      logic               flag;
      logic               nostep;
      logic               rsat;
   } ratio_side_type;

endpackage

// ----- sv/adam_optimizer_update_top.sv -----
// Adam update: moment stores, bias correction, root, ratio and weight step.
//
// req channel: one item per transfer. A begin-step item (kind 1) scales the
// running beta powers and gives no result. An element item reads both moment
// stores at index (wrapped modulo DEPTH), writes the updated moments back and
// gives one rsp transfer with the new weight and the overflow flag.
// Items are taken one per cycle while rsp is not stalled and the store clear
// is done. An element item passes stage B, the moment register, the moment
// dividers (32 stages), the square root (28 stages) and the ratio divider
// (39 stages), then the multiply, sum and output registers.
// Back-to-back items at the same index are forwarded from the moment stage.
// After reset the moment stores are cleared one entry per cycle, with req_ready
// low until all entries are clear; csr writes are taken throughout.
// When rsp stalls, the whole pipeline holds and req_ready drops; nothing is
// lost or repeated. csr writes are meant for idle periods only.
module adam_optimizer_update_top #(
   parameter int unsigned DEPTH      = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  adam_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output adam_pkg::rsp_type              rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [adam_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [adam_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [adam_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);
   import adam_pkg::*;

   localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned MOD_D   = (DEPTH < 4096) ? DEPTH : 4096;
   localparam logic [25:0] MOD_RCP = 26'((2**26 + MOD_D - 1) / MOD_D);
   localparam logic [12:0] MOD_DV  = 13'(MOD_D);
   localparam logic signed [65:0] WMAX = (66'sd1 <<< (VAL_W - 1)) - 66'sd1;
   localparam logic signed [65:0] WMIN = -WMAX - 66'sd1;

   // ---------------- configuration ----------------
   logic [15:0] b1_ff, b2_ff;
   logic [23:0] eps_ff, ss_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_ff  <= BETA_FIRST_RST;
         b2_ff  <= BETA_SECOND_RST;
         eps_ff <= EPS_TERM_RST;
         ss_ff  <= STEP_SIZE_RST;
      end else if (csr_wr) begin
         case (reg_idx_type'(csr_paddr[3:2]))
            REG_BETA_FIRST:  b1_ff  <= csr_pwdata[15:0];
            REG_BETA_SECOND: b2_ff  <= csr_pwdata[15:0];
            REG_EPS_TERM:    eps_ff <= csr_pwdata[23:0];
            REG_STEP_SIZE:   ss_ff  <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx_type'(csr_paddr[3:2]))
         REG_BETA_FIRST:  csr_prdata = {16'b0, b1_ff};
         REG_BETA_SECOND: csr_prdata = {16'b0, b2_ff};
         REG_EPS_TERM:    csr_prdata = {8'b0, eps_ff};
         REG_STEP_SIZE:   csr_prdata = {8'b0, ss_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic adv, acc, elem_acc;
   logic rsp_valid_ff;
   logic clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !clr_active_ff;
   assign acc       = req_valid && req_ready;
   assign elem_acc  = acc && (req_data.kind == KIND_ELEMENT);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // ---------------- beta powers ----------------
   logic [31:0] bp1_ff, bp2_ff;
   logic [47:0] pw1, pw2;

   assign pw1 = bp1_ff * b1_ff;
   assign pw2 = bp2_ff * b2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bp1_ff <= ONE_Q31;
         bp2_ff <= ONE_Q31;
      end else if (acc && (req_data.kind == KIND_STEP)) begin
         bp1_ff <= pw1[47:16];
         bp2_ff <= pw2[47:16];
      end
   end

   // ---------------- intake: address, gradient square, bias terms ----------------
   logic [37:0] idx_prod;
   logic [11:0] idx_quo;
   logic [25:0] idx_rem;
   logic [11:0] addr_a;
   logic [31:0] ag_a;
   logic [63:0] sq_full;
   logic [31:0] sq_a;
   logic        sqsat_a;
   logic [31:0] c1_a, c2_a;

   assign idx_prod = req_data.index * MOD_RCP;
   assign idx_quo  = idx_prod[37:26];
   assign idx_rem  = 26'(req_data.index) - 26'(idx_quo * MOD_DV);
   assign addr_a   = idx_rem[11:0];

   assign ag_a    = req_data.gradient[31] ? 32'(-req_data.gradient) : req_data.gradient;
   assign sq_full = 64'(ag_a) * 64'(ag_a);
   assign sqsat_a = |sq_full[63:56];
   assign sq_a    = sqsat_a ? 32'hFFFF_FFFF : sq_full[55:24];

   assign c1_a = (bp1_ff >= ONE_Q31) ? 32'd0 : ONE_Q31 - bp1_ff;
   assign c2_a = (bp2_ff >= ONE_Q31) ? 32'd0 : ONE_Q31 - bp2_ff;

   // ---------------- stage B: read data arrives ----------------
   logic               b_valid_ff, b_fwd_ff, b_sqsat_ff;
   logic [11:0]        b_addr_ff;
   logic signed [31:0] b_w_ff, b_g_ff;
   logic [31:0]        b_sq_ff, b_c1_ff, b_c2_ff;
   logic               c_valid_ff;
   logic [11:0]        c_addr_ff;
   logic               fwd_in;

   // same index as the item now leaving B: its write lands on this read
   assign fwd_in = b_valid_ff && (b_addr_ff == addr_a);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= elem_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_fwd_ff   <= fwd_in;
         b_addr_ff  <= addr_a;
         b_w_ff     <= req_data.weight;
         b_g_ff     <= req_data.gradient;
         b_sq_ff    <= sq_a;
         b_sqsat_ff <= sqsat_a;
         b_c1_ff    <= c1_a;
         b_c2_ff    <= c2_a;
      end
   end

   // ---------------- moment store ----------------
   logic [63:0]        ram_rd;
   logic               ram_we;
   logic [AW-1:0]      ram_wa;
   logic [63:0]        ram_wd;
   logic signed [31:0] mn_b;
   logic [31:0]        vn_b;

   assign ram_we = clr_active_ff || (b_valid_ff && adv);
   assign ram_wa = clr_active_ff ? clr_addr_ff : AW'(b_addr_ff);
   assign ram_wd = clr_active_ff ? 64'd0 : {vn_b, mn_b};

   adam_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_moment_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (elem_acc),
      .rd_addr (AW'(addr_a)),
      .rd_data (ram_rd)
   );

   // ---------------- moment update ----------------
   logic signed [31:0] c_m_ff;
   logic [31:0]        c_v_ff;
   logic signed [31:0] m_old;
   logic [31:0]        v_old;
   logic [16:0]        wb1, wb2;
   logic signed [48:0] t1, t2;
   logic signed [49:0] msum;
   logic [49:0]        vsum;
   logic [31:0]        am_b;

   assign m_old = b_fwd_ff ? c_m_ff : $signed(ram_rd[31:0]);
   assign v_old = b_fwd_ff ? c_v_ff : ram_rd[63:32];
   assign wb1   = 17'h10000 - 17'(b1_ff);
   assign wb2   = 17'h10000 - 17'(b2_ff);
   assign t1    = $signed({1'b0, b1_ff}) * m_old;
   assign t2    = $signed({1'b0, wb1}) * b_g_ff;
   assign msum  = t1 + t2;
   assign mn_b  = msum[47:16];   // arithmetic floor, result fits 32 bits
   assign vsum  = b2_ff * v_old + wb2 * b_sq_ff;
   assign vn_b  = vsum[47:16];
   assign am_b  = mn_b[31] ? 32'(-mn_b) : mn_b;

   logic [31:0]        c_am_ff, c_c1_ff, c_c2_ff;
   logic signed [31:0] c_w_ff;
   logic               c_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_m_ff    <= mn_b;
         c_v_ff    <= vn_b;
         c_am_ff   <= am_b;
         c_c1_ff   <= b_c1_ff;
         c_c2_ff   <= b_c2_ff;
         c_addr_ff <= b_addr_ff;
         c_w_ff    <= b_w_ff;
         c_flag_ff <= b_sqsat_ff;
      end
   end

   // ---------------- bias correction dividers ----------------
   div_side_type d_side_in, d_side_out;
   logic         d_valid_out, dv_valid_unused;
   logic [31:0]  qm, qv;
   logic [$bits(div_side_type)-1:0] dv_side_unused;

   always_comb begin
      d_side_in.addr   = c_addr_ff;
      d_side_in.weight = c_w_ff;
      d_side_in.neg    = c_m_ff[31];
      d_side_in.flag   = c_flag_ff;
      d_side_in.nostep = (c_c1_ff == 32'd0) || (c_c2_ff == 32'd0);
      d_side_in.msat   = (c_am_ff >= c_c1_ff);
      d_side_in.vsat   = ({1'b0, c_v_ff} >= {c_c2_ff, 1'b0});
   end

   adam_div #(
      .DW (MD_W),
      .QW (MQ_W),
      .SW ($bits(div_side_type))
   ) u_div_m (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (c_valid_ff),
      .in_rem    ({1'b0, c_am_ff[31:1]}),
      .in_den    (c_c1_ff),
      .in_low    ({c_am_ff[0], 31'b0}),
      .in_side   (d_side_in),
      .out_valid (d_valid_out),
      .out_quo   (qm),
      .out_side  (d_side_out)
   );

   adam_div #(
      .DW (MD_W),
      .QW (MQ_W),
      .SW ($bits(div_side_type))
   ) u_div_v (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (c_valid_ff),
      .in_rem    ({1'b0, c_v_ff[31:1]}),
      .in_den    (c_c2_ff),
      .in_low    ({c_v_ff[0], 31'b0}),
      .in_side   (d_side_in),
      .out_valid (dv_valid_unused),
      .out_quo   (qv),
      .out_side  (dv_side_unused)
   );

   // ---------------- square root ----------------
   root_side_type r_side_in, r_side_out;
   logic [31:0]   vh;
   logic          r_valid_out;
   logic [27:0]   root;

   assign vh = d_side_out.vsat ? 32'hFFFF_FFFF : qv;

   always_comb begin
      r_side_in.addr   = d_side_out.addr;
      r_side_in.weight = d_side_out.weight;
      r_side_in.neg    = d_side_out.neg;
      r_side_in.flag   = d_side_out.flag || d_side_out.msat || d_side_out.vsat;
      r_side_in.nostep = d_side_out.nostep;
      r_side_in.mh     = d_side_out.msat ? 31'h7FFF_FFFF : qm[30:0];
   end

   adam_sqrt #(
      .RW (ROOT_W),
      .SW ($bits(root_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (d_valid_out),
      .in_rad    ({vh, 24'b0}),
      .in_side   (r_side_in),
      .out_valid (r_valid_out),
      .out_root  (root),
      .out_side  (r_side_out)
   );

   // ---------------- ratio divider ----------------
   ratio_side_type q_side_in, q_side_out;
   logic [23:0]    eps1;
   logic [28:0]    den;
   logic           q_valid_out;
   logic [38:0]    qr;

   assign eps1 = (eps_ff == 24'd0) ? 24'd1 : eps_ff;
   assign den  = 29'(root) + 29'(eps1);

   always_comb begin
      q_side_in.addr   = r_side_out.addr;
      q_side_in.weight = r_side_out.weight;
      q_side_in.neg    = r_side_out.neg;
      q_side_in.flag   = r_side_out.flag;
      q_side_in.nostep = r_side_out.nostep;
      q_side_in.rsat   = ({13'b0, r_side_out.mh} >= {den, 15'b0});
   end

   adam_div #(
      .DW (DEN_W),
      .QW (RATIO_W),
      .SW ($bits(ratio_side_type))
   ) u_div_r (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (r_valid_out),
      .in_rem    (29'(r_side_out.mh[30:15])),
      .in_den    (den),
      .in_low    ({r_side_out.mh[14:0], 24'b0}),
      .in_side   (q_side_in),
      .out_valid (q_valid_out),
      .out_quo   (qr),
      .out_side  (q_side_out)
   );

   // ---------------- step size multiply, split in two partials ----------------
   logic [38:0]    ratio;
   logic           p_valid_ff, s_valid_ff;
   logic [42:0]    p_hi_ff;
   logic [43:0]    p_lo_ff;
   ratio_side_type p_side_ff, s_side_ff, p_side_in;
   logic [62:0]    prod;
   logic [38:0]    s_stp_ff;

   assign ratio = q_side_out.rsat ? {RATIO_W{1'b1}} : qr;

   always_comb begin
      p_side_in      = q_side_out;
      p_side_in.flag = q_side_out.flag || q_side_out.rsat;
   end

   assign prod = {p_hi_ff, 20'b0} + 63'(p_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= q_valid_out;
         s_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_hi_ff   <= ratio[38:20] * ss_ff;
         p_lo_ff   <= ratio[19:0] * ss_ff;
         p_side_ff <= p_side_in;
         s_stp_ff  <= prod[62:24];
         s_side_ff <= p_side_ff;
      end
   end

   // ---------------- weight update and saturation ----------------
   logic signed [65:0] w66, stp66, nw66, sat66;
   logic               fin_flag;
   rsp_type            rsp_in, rsp_data_ff;

   assign w66   = 66'(s_side_ff.weight);
   assign stp66 = $signed({27'b0, s_stp_ff});
   assign nw66  = s_side_ff.neg ? w66 + stp66 : w66 - stp66;

   always_comb begin
      sat66    = nw66;
      fin_flag = s_side_ff.flag;
      if (s_side_ff.nostep) begin
         sat66    = w66;
         fin_flag = 1'b1;
      end else if (nw66 > WMAX) begin
         sat66    = WMAX;
         fin_flag = 1'b1;
      end else if (nw66 < WMIN) begin
         sat66    = WMIN;
         fin_flag = 1'b1;
      end
      rsp_in.index_out  = s_side_ff.addr;
      rsp_in.new_weight = sat66[31:0];
      rsp_in.overflow   = fin_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req_ready)
      else $error("req_ready high during store clear");

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_fwd_ff) |-> (c_valid_ff && (c_addr_ff == b_addr_ff)))
      else $error("forwarded moment has no matching producer");

   a_power_bound: assert property (@(posedge clock) disable iff (reset)
      acc |=> ((bp1_ff <= ONE_Q31) && (bp2_ff <= ONE_Q31)))
      else $error("beta power above one");
`endif
endmodule

// ----- sv/adam_ram.sv -----
// Generic single write port, single registered read port RAM.
module adam_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/adam_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module adam_div #(
   parameter int unsigned DW = 32,
   parameter int unsigned QW = 32,
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_den,
   input  logic [QW-1:0] in_low,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   // in_rem is the numerator above the quotient bits, in_low the bits below
   logic          valid_ff [QW];
   logic [DW-1:0] rem_ff   [QW];
   logic [DW-1:0] den_ff   [QW];
   logic [QW-1:0] low_ff   [QW];
   logic [QW-1:0] quo_ff   [QW];
   logic [SW-1:0] side_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          prev_valid;
      logic [DW-1:0] prev_rem;
      logic [DW-1:0] prev_den;
      logic [QW-1:0] prev_low;
      logic [QW-1:0] prev_quo;
      logic [SW-1:0] prev_side;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          take;
      logic [DW-1:0] rem_in;

      if (k == 0) begin : g_head
         assign prev_valid = in_valid;
         assign prev_rem   = in_rem;
         assign prev_den   = in_den;
         assign prev_low   = in_low;
         assign prev_quo   = '0;
         assign prev_side  = in_side;
      end else begin : g_body
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_den   = den_ff[k-1];
         assign prev_low   = low_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
         assign prev_side  = side_ff[k-1];
      end

      assign trial  = {prev_rem, prev_low[QW-1]};
      assign diff   = trial - {1'b0, prev_den};
      assign take   = (trial >= {1'b0, prev_den});
      assign rem_in = take ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= prev_den;
            low_ff[k]  <= {prev_low[QW-2:0], 1'b0};
            quo_ff[k]  <= {prev_quo[QW-2:0], take};
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];
endmodule

// ----- sv/adam_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module adam_sqrt #(
   parameter int unsigned RW = 28,
   parameter int unsigned SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [SW-1:0]   out_side
);
   logic            valid_ff [RW];
   logic [RW+1:0]   rem_ff   [RW];
   logic [RW-1:0]   root_ff  [RW];
   logic [2*RW-1:0] rad_ff   [RW];
   logic [SW-1:0]   side_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic            prev_valid;
      logic [RW+1:0]   prev_rem;
      logic [RW-1:0]   prev_root;
      logic [2*RW-1:0] prev_rad;
      logic [SW-1:0]   prev_side;
      logic [RW+3:0]   trial;
      logic [RW+3:0]   test;
      logic [RW+3:0]   diff;
      logic            take;
      logic [RW+1:0]   rem_in;

      if (k == 0) begin : g_head
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_rad   = in_rad;
         assign prev_side  = in_side;
      end else begin : g_body
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_root  = root_ff[k-1];
         assign prev_rad   = rad_ff[k-1];
         assign prev_side  = side_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      assign trial  = {prev_rem, prev_rad[2*RW-1:2*RW-2]};
      assign test   = {2'b00, prev_root, 2'b01};
      assign diff   = trial - test;
      assign take   = (trial >= test);
      assign rem_in = take ? diff[RW+1:0] : trial[RW+1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {prev_root[RW-2:0], take};
            rad_ff[k]  <= {prev_rad[2*RW-3:0], 2'b00};
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];
endmodule

// ----- tb/sv/adam_update_checker.sv -----
// Checker for the Adam update block: predicts new weights and compares rsp transfers.
module adam_update_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  adam_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  adam_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [adam_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [adam_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic                        csr_pready,
   output int                          fail_count,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import adam_pkg::*;

   logic [31:0] first_m [4096];
   logic [31:0] second_m [4096];
   logic [31:0] pow_first, pow_second;
   logic [15:0] beta1, beta2;
   logic [23:0] eps, lr;
   rsp_type     expected_weights[$];

   assign pending = expected_weights.size();

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // updates the moment stores and returns the new weight
   function automatic rsp_type update_element(req_type it);
      rsp_type r;
      longint m, g, w, mn, nw;
      longint unsigned ag, sq, vn, c1, c2, am, mh, vh, root, den, ratio, stp;
      logic flag;
      flag = 1'b0;
      m = longint'(signed'(first_m[it.index]));
      g = longint'(it.gradient);
      w = longint'(it.weight);
      mn = (longint'(beta1) * m + (65536 - longint'(beta1)) * g) >>> 16;
      first_m[it.index] = mn[31:0];
      ag = g < 0 ? -g : g;
      sq = (ag * ag) >> 24;
      if (sq > 64'hFFFF_FFFF) begin
         sq = 64'hFFFF_FFFF;
         flag = 1'b1;
      end
      vn = (longint'(beta2) * longint'(second_m[it.index])
            + (65536 - longint'(beta2)) * sq) >> 16;
      second_m[it.index] = vn[31:0];
      c1 = pow_first >= ONE_Q31 ? 0 : 64'h8000_0000 - pow_first;
      c2 = pow_second >= ONE_Q31 ? 0 : 64'h8000_0000 - pow_second;
      if (c1 == 0 || c2 == 0) begin
         nw = w;
         flag = 1'b1;
      end else begin
         am = mn < 0 ? -mn : mn;
         mh = (am << 31) / c1;
         vh = (vn << 31) / c2;
         if (mh > 64'h7FFF_FFFF) begin
            mh = 64'h7FFF_FFFF;
            flag = 1'b1;
         end
         if (vh > 64'hFFFF_FFFF) begin
            vh = 64'hFFFF_FFFF;
            flag = 1'b1;
         end
         root = int_sqrt(vh << 24);
         den = root + (eps != 0 ? eps : 1);
         ratio = (mh << 24) / den;
         if (ratio > (64'd1 << 39) - 1) begin
            ratio = (64'd1 << 39) - 1;
            flag = 1'b1;
         end
         stp = (ratio * lr) >> 24;
         nw = mn < 0 ? w + longint'(stp) : w - longint'(stp);
         if (nw > 64'sh7FFF_FFFF) begin
            nw = 64'sh7FFF_FFFF;
            flag = 1'b1;
         end else if (nw < -64'sh8000_0000) begin
            nw = -64'sh8000_0000;
            flag = 1'b1;
         end
      end
      r.index_out = it.index;
      r.new_weight = nw[31:0];
      r.overflow = flag;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         for (int i = 0; i < 4096; i++) begin
            first_m[i] = '0;
            second_m[i] = '0;
         end
         pow_first = ONE_Q31;
         pow_second = ONE_Q31;
         beta1 = BETA_FIRST_RST;
         beta2 = BETA_SECOND_RST;
         eps = EPS_TERM_RST;
         lr = STEP_SIZE_RST;
         expected_weights.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_weights.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected rsp transfer %p", $realtime, rsp_data);
            end else begin
               exp_r = expected_weights.pop_front();
               if (rsp_data.index_out !== exp_r.index_out
                   || rsp_data.new_weight !== exp_r.new_weight
                   || rsp_data.overflow !== exp_r.overflow) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: expected idx %0d w %0d ovf %0b, got %0d w %0d ovf %0b",
                        $realtime, exp_r.index_out, exp_r.new_weight, exp_r.overflow,
                        rsp_data.index_out, rsp_data.new_weight, rsp_data.overflow);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.kind == KIND_STEP) begin
               pow_first = 32'((64'(pow_first) * beta1) >> 16);
               pow_second = 32'((64'(pow_second) * beta2) >> 16);
            end else begin
               expected_weights.push_back(update_element(req_data));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[1:0] == 2'b00) begin
            case (reg_idx_type'(csr_paddr[3:2]))
               REG_BETA_FIRST:  beta1 = csr_pwdata[15:0];
               REG_BETA_SECOND: beta2 = csr_pwdata[15:0];
               REG_EPS_TERM:    eps = csr_pwdata[23:0];
               REG_STEP_SIZE:   lr = csr_pwdata[23:0];
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- tb/sv/adam_optimizer_update_top_test.sv -----
// Testbench top for the Adam update block: stimulus, idling and verdict.
module adam_optimizer_update_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import adam_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;
   int                  fail_count, pending;
   int                  send_idle = 0, recv_idle = 0;
   int                  quiet_cycles = 0;

   adam_optimizer_update_top i_dut (.*);

   adam_update_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .fail_count, .pending
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL adam_optimizer_update_top");
         $finish;
      end
   end

   task automatic send_item(req_type it);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic element(logic [11:0] idx, logic [31:0] w, logic [31:0] g);
      send_item('{kind: KIND_ELEMENT, index: idx, weight: w, gradient: g});
   endtask

   task automatic begin_step();
      req_type it;
      it = $bits(req_type)'({$urandom, $urandom, $urandom});
      it.kind = KIND_STEP;
      send_item(it);
   endtask

   // lets the pipeline empty so the registers can change
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(reg_idx_type r, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [15:0] b1, logic [15:0] b2, logic [23:0] e, logic [23:0] s);
      csr_write(REG_BETA_FIRST, 32'(b1));
      csr_write(REG_BETA_SECOND, 32'(b2));
      csr_write(REG_EPS_TERM, 32'(e));
      csr_write(REG_STEP_SIZE, 32'(s));
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($signed($urandom_range(65535)) - 32768);
         default: return 32'($signed($urandom_range(33554432)) - 16777216);
      endcase
   endfunction

   task automatic random_item();
      logic [11:0] idx;
      if ($urandom_range(9) == 0) begin
         begin_step();
      end else begin
         idx = $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(15));
         element(idx, pick_value(), pick_value());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no step begun yet: weight passes through with the flag set
      element(12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      element(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF);
      element(12'd0, 32'h0100_0000, 32'h0100_0000);
      begin_step();
      element(12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      element(12'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      element(12'd4095, 32'h0000_0000, 32'h0000_0000);
      element(12'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      element(12'd2, 32'h0100_0000, 32'h0080_0000);
      begin_step();
      element(12'd2, 32'h0100_0000, 32'hFF80_0000);
      element(12'd2, 32'h0100_0000, 32'hFF80_0000);
      drain();
      // zero epsilon, extreme betas and step size
      configure(16'd65535, 16'd0, 24'd0, 24'hFF_FFFF);
      begin_step();
      element(12'd3, 32'h0000_0000, 32'h0010_0000);
      element(12'd3, 32'h7FFF_0000, 32'hFFF0_0000);
      element(12'd5, 32'h8000_0000, 32'h0000_0001);
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin send_idle = 37; recv_idle = 59; end
            1: begin send_idle = 59; recv_idle = 37; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         case (p)
            0: configure(BETA_FIRST_RST, BETA_SECOND_RST, EPS_TERM_RST, STEP_SIZE_RST);
            1: configure(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
            2: configure(16'd0, 16'd0, 24'd0, 24'd0);
            default: configure(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
         endcase
         for (int n = 0; n < 155; n++) begin
            // stretches without idling
            if (n == 60) begin
               send_idle = 0;
               recv_idle = 0;
            end
            if (n == 90 && p < 4) begin
               send_idle = p < 2 ? 37 : 59;
               recv_idle = p < 2 ? 59 : 37;
            end
            random_item();
         end
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("PASS adam_optimizer_update_top");
      else
         $display("FAIL adam_optimizer_update_top");
      $finish;
   end
endmodule

// ----- filelist.f -----
sv/adam_pkg.sv
sv/adam_ram.sv
sv/adam_div.sv
sv/adam_sqrt.sv
sv/adam_optimizer_update_top.sv
tb/sv/adam_update_checker.sv
tb/sv/adam_optimizer_update_top_test.sv
